/* rtl/mdp_pkg.sv */
// ----------------------------------------------------------------------------
// mdp_pkg: shared types and constants for the duplicate point merge unit
// Operation codes, status codes and the point record used by the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package mdp_pkg;

    localparam int COORD_W = 32;
    localparam int ID_W    = 10;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMAP  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_INS  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_t;

    function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        if (a_nan || b_nan)
            return 1'b0;
        if ((a[30:0] == '0) && (b[30:0] == '0))
            return 1'b1;
        return a == b;
    endfunction

endpackage
`default_nettype wire

/* rtl/mdp_cell.sv */
// ----------------------------------------------------------------------------
// mdp_cell: one stored unique point in the search chain
// Holds a point, compares it with the probe, and forwards the lowest hit id.
// ----------------------------------------------------------------------------
`default_nettype none
module mdp_cell #(
    parameter int IDX_W = 10,
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                write_en,
    input  wire mdp_pkg::point_t     write_point,
    input  wire logic                occupied,
    input  wire mdp_pkg::point_t     probe,
    input  wire logic                hit_in,
    input  wire logic [IDX_W-1:0]    hit_id_in,
    output logic                     hit_out,
    output logic [IDX_W-1:0]         hit_id_out
);
    import mdp_pkg::*;

    point_t point_reg;
    logic   match;

    always_ff @(posedge clk)
    begin
        if (write_en)
            point_reg <= write_point;
    end

    assign match = occupied && coord_equal(point_reg.x, probe.x)
                 && coord_equal(point_reg.y, probe.y)
                 && coord_equal(point_reg.z, probe.z);

    always_comb
    begin
        if (match)
        begin
            hit_out    = 1'b1;
            hit_id_out = IDX_W'(INDEX);
        end
        else
        begin
            hit_out    = hit_in;
            hit_id_out = hit_id_in;
        end
    end

endmodule
`default_nettype wire

/* rtl/mdp_chain.sv */
// ----------------------------------------------------------------------------
// mdp_chain: row of point cells scanned in registered segments
// Cells are grouped into segments of SEG cells; one segment is checked per
// cycle, and the running hit travels from segment to segment in a register.
// ----------------------------------------------------------------------------
`default_nettype none
module mdp_chain #(
    parameter int MAX_POINTS = 1024,
    parameter int IDX_W      = 10,
    parameter int SEG        = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire mdp_pkg::point_t     probe,
    input  wire logic [IDX_W:0]      count,
    input  wire logic                write_en,
    input  wire logic [IDX_W-1:0]    write_addr,
    output logic                     done,
    output logic                     hit,
    output logic [IDX_W-1:0]         hit_id
);
    import mdp_pkg::*;

    localparam int NSEG  = (MAX_POINTS + SEG - 1) / SEG;
    localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;

    logic [NSEG-1:0]        seg_hit;
    logic [IDX_W-1:0]       seg_id [NSEG];
    logic [SEG_W:0]         seg_reg, seg_next;
    logic                   busy_reg, busy_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       id_reg, id_next;
    logic [SEG_W:0]         seg_last;

    genvar s, c;
    generate
        for (s = 0; s < NSEG; s++)
        begin : g_seg
            logic             h [SEG+1];
            logic [IDX_W-1:0] i [SEG+1];
            assign h[SEG] = 1'b0;
            assign i[SEG] = '0;
            for (c = SEG - 1; c >= 0; c--)
            begin : g_cell
                localparam int IDX = s * SEG + c;
                if (IDX < MAX_POINTS)
                begin : g_real
                    mdp_cell #(.IDX_W(IDX_W), .INDEX(IDX)) u_cell (
                        .clk        (clk),
                        .write_en   (write_en && (write_addr == IDX_W'(IDX))),
                        .write_point(probe),
                        .occupied   (count > (IDX_W+1)'(IDX)),
                        .probe      (probe),
                        .hit_in     (h[c+1]),
                        .hit_id_in  (i[c+1]),
                        .hit_out    (h[c]),
                        .hit_id_out (i[c])
                    );
                end
                else
                begin : g_pad
                    assign h[c] = h[c+1];
                    assign i[c] = i[c+1];
                end
            end
            assign seg_hit[s] = h[0];
            assign seg_id[s]  = i[0];
        end
    endgenerate

    assign seg_last = (SEG_W+1)'(NSEG - 1);

    always_comb
    begin
        seg_next  = seg_reg;
        busy_next = busy_reg;
        hit_next  = hit_reg;
        id_next   = id_reg;
        done      = 1'b0;
        if (start)
        begin
            seg_next  = '0;
            busy_next = 1'b1;
            hit_next  = 1'b0;
            id_next   = '0;
        end
        else if (busy_reg)
        begin
            if (!hit_reg && seg_hit[seg_reg[SEG_W-1:0]])
            begin
                hit_next = 1'b1;
                id_next  = seg_id[seg_reg[SEG_W-1:0]];
            end
            if (seg_reg == seg_last
                || ((IDX_W+1)'(seg_reg + 1'b1) * (IDX_W+1)'(SEG) >= count))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
                seg_next = seg_reg + 1'b1;
        end
    end

    assign hit    = hit_next;
    assign hit_id = id_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= '0;
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            id_reg   <= '0;
        end
        else
        begin
            seg_reg  <= seg_next;
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            id_reg   <= id_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/merge_duplicate_points_unit.sv */
// ----------------------------------------------------------------------------
// merge_duplicate_points_unit: vertex welding table over a chain of point cells
// An insert scans eight cells per cycle, up to the count of unique points.
// A new item is taken only after the previous result has been taken.
// Reset: counts to zero; stored points and id table undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module merge_duplicate_points_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] x_bits,
    input  wire logic [31:0] y_bits,
    input  wire logic [31:0] z_bits,
    input  wire logic [9:0]  insert_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       unique_id,
    output logic             is_new,
    output logic [1:0]       status
);
    import mdp_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    state_t              state_reg, state_next;
    logic [IDX_W:0]      ucount_reg, ucount_next;
    logic [IDX_W:0]      icount_reg, icount_next;
    op_t                 op_reg;
    point_t              pt_reg;
    logic [9:0]          num_reg;
    logic [IDX_W-1:0]    id_mem [MAX_POINTS];
    logic [IDX_W-1:0]    rd_reg;
    logic                out_valid_reg;
    logic [9:0]          uid_reg, uid_next;
    logic                new_reg, new_next;
    logic [1:0]          st_reg, st_next;
    logic                accept, start, scan_done, hit, wr_pt, wr_id;
    logic [IDX_W-1:0]    hit_id, wr_id_val;
    logic                full, remap_bad, load;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign full = (icount_reg >= (IDX_W+1)'(MAX_POINTS)) || (ucount_reg > icount_reg);
    assign remap_bad = ((IDX_W+11)'(num_reg) >= (IDX_W+11)'(icount_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(operation);
            pt_reg  <= '{x: x_bits, y: y_bits, z: z_bits};
            num_reg <= insert_number;
        end
        if (wr_id)
            id_mem[icount_reg[IDX_W-1:0]] <= wr_id_val;
        rd_reg <= id_mem[IDX_W'(num_reg)];
    end

    // scan starts with the transfer; a full table ignores its outcome
    assign start = accept && (operation == OP_INSERT);

    mdp_chain #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .SEG(8)) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .probe     (pt_reg),
        .count     (ucount_reg),
        .write_en  (wr_pt),
        .write_addr(ucount_reg[IDX_W-1:0]),
        .done      (scan_done),
        .hit       (hit),
        .hit_id    (hit_id)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_SCAN;
            S_SCAN:
            begin
                if (op_reg == OP_INSERT && !full)
                begin
                    if (scan_done) state_next = S_DONE;
                end
                else if (op_reg == OP_REMAP && !remap_bad)
                    state_next = S_READ;
                else
                    state_next = S_DONE;
            end
            S_READ: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ucount_next = ucount_reg;
        icount_next = icount_reg;
        wr_pt     = 1'b0;
        wr_id     = 1'b0;
        wr_id_val = hit_id;
        load      = 1'b0;
        uid_next  = uid_reg;
        new_next  = new_reg;
        st_next   = st_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                if (op_reg == OP_INSERT && full)
                begin
                    load = 1'b1; uid_next = '0; new_next = 1'b0; st_next = ST_FULL;
                end
                else if (op_reg == OP_INSERT)
                begin
                    if (scan_done)
                    begin
                        load  = 1'b1;
                        wr_id = 1'b1;
                        icount_next = icount_reg + 1'b1;
                        st_next = ST_OK;
                        if (hit)
                        begin
                            uid_next = 10'(hit_id); new_next = 1'b0;
                        end
                        else
                        begin
                            wr_pt = 1'b1;
                            wr_id_val = ucount_reg[IDX_W-1:0];
                            ucount_next = ucount_reg + 1'b1;
                            uid_next = 10'(ucount_reg[IDX_W-1:0]); new_next = 1'b1;
                        end
                    end
                end
                else if (op_reg == OP_REMAP)
                begin
                    if (remap_bad)
                    begin
                        load = 1'b1; uid_next = '0; new_next = 1'b0; st_next = ST_NO_INS;
                    end
                end
                else
                begin
                    load = 1'b1; uid_next = '0; new_next = 1'b0; st_next = ST_OK;
                    if (op_reg == OP_CLEAR)
                    begin
                        ucount_next = '0; icount_next = '0;
                    end
                end
            end
            S_READ:
            begin
                load = 1'b1; uid_next = 10'(rd_reg); new_next = 1'b0; st_next = ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ucount_reg    <= '0;
            icount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ucount_reg <= ucount_next;
            icount_reg <= icount_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        uid_reg <= uid_next;
        new_reg <= new_next;
        st_reg  <= st_next;
    end

    assign out_valid = out_valid_reg;
    assign unique_id = uid_reg;
    assign is_new    = new_reg;
    assign status    = st_reg;

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        ucount_reg <= icount_reg) else $error("unique count exceeds insert count");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready) else $error("input taken while result pending");
    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && new_reg) |-> (st_reg == ST_OK))
        else $error("new point with error status");

endmodule
`default_nettype wire
